// ----- hw/rtl/jssv_pkg.sv -----
// Shared types, codes and character helpers for the JSON subset stream validator.
package jssv_pkg;

  // Default nesting limit.
  localparam int DEFAULT_MAX_DEPTH = 64;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_VALUE     = 4'd0,
    PH_OBJ_OPEN  = 4'd1,
    PH_ARR_OPEN  = 4'd2,
    PH_STR       = 4'd3,
    PH_KEY_STR   = 4'd4,
    PH_AFTER_KEY = 4'd5,
    PH_LIT_T     = 4'd6,
    PH_LIT_F     = 4'd7,
    PH_AFTER_VAL = 4'd8,
    PH_OBJ_COMMA = 4'd9,
    PH_ARR_COMMA = 4'd10,
    PH_DONE      = 4'd11
  } phase_t;

  // Result status codes.
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_EXP_VALUE   = 4'd1;
  localparam logic [3:0] ST_UNSUPPORTED = 4'd2;
  localparam logic [3:0] ST_EXP_RBRACE  = 4'd3;
  localparam logic [3:0] ST_EXP_RBRACK  = 4'd4;
  localparam logic [3:0] ST_EXP_STR_END = 4'd5;
  localparam logic [3:0] ST_EXP_TRUE    = 4'd6;
  localparam logic [3:0] ST_EXP_FALSE   = 4'd7;
  localparam logic [3:0] ST_EXP_COLON   = 4'd8;
  localparam logic [3:0] ST_BAD_LIST    = 4'd9;
  localparam logic [3:0] ST_TOO_DEEP    = 4'd10;

  // Top value kinds.
  localparam logic [2:0] KIND_OBJECT = 3'd0;
  localparam logic [2:0] KIND_ARRAY  = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_BOOL   = 3'd3;
  localparam logic [2:0] KIND_NONE   = 3'd4;

  // Characters.
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [2:0] LEN_TRUE  = 3'd4;
  localparam logic [2:0] LEN_FALSE = 3'd5;

  // Stack command from the parser step to the container stack.
  typedef struct packed {
    logic push;
    logic pop;
    logic is_array;
    logic clear;
  } stack_op_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SPACE, CH_LF, CH_CR, CH_TAB};
  endfunction

  // Letters of "true" by position.
  function automatic logic [7:0] true_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h74;
      3'd1:    ch = 8'h72;
      3'd2:    ch = 8'h75;
      3'd3:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Letters of "false" by position.
  function automatic logic [7:0] false_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h66;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h6C;
      3'd3:    ch = 8'h73;
      3'd4:    ch = 8'h65;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ----- hw/rtl/jssv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module jssv_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/jssv_stack.sv -----
// Container stack: depth counter, cached top entry and prefetched entry below it.
module jssv_stack #(
  parameter int MAX_DEPTH = jssv_pkg::DEFAULT_MAX_DEPTH,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                op_en,
  input  jssv_pkg::stack_op_t op,
  output logic [DW-1:0]       depth,
  output logic                top_is_array,
  output logic                below_is_array
);
  import jssv_pkg::*;

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [DW-1:0] depth_r, depth_nxt;
  logic          top_r, top_nxt;
  logic          we;
  logic [DW-1:0] raddr_full;

  // Next depth and top entry
  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    we        = 1'b0;
    if (op_en) begin
      if (op.clear) begin
        depth_nxt = '0;
      end else if (op.push) begin
        depth_nxt = depth_r + DW'(1);
        top_nxt   = op.is_array;
        we        = 1'b1;
      end else if (op.pop) begin
        depth_nxt = depth_r - DW'(1);
        top_nxt   = below_is_array;
      end
    end
  end

  // Prefetch the entry two below the next depth, i.e. below the next top
  assign raddr_full = depth_nxt - DW'(2);

  jssv_ram #(
    .WIDTH(1),
    .DEPTH(MAX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (depth_r[AW-1:0]),
    .wdata (op.is_array),
    .raddr (raddr_full[AW-1:0]),
    .rdata (below_is_array)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      top_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      top_r   <= top_nxt;
    end
  end

  assign depth        = depth_r;
  assign top_is_array = top_r;

endmodule

// ----- hw/rtl/jssv_step.sv -----
// Per-byte parser step: next phase, stack command and result for one byte.
module jssv_step #(
  parameter int MAX_DEPTH = jssv_pkg::DEFAULT_MAX_DEPTH,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  jssv_pkg::phase_t    phase,
  input  logic [2:0]          lit_idx,
  input  logic [2:0]          top_kind,
  input  logic [DW-1:0]       depth,
  input  logic                top_is_array,
  input  logic                below_is_array,
  input  logic [7:0]          byte_value,
  input  logic                last_byte,
  output jssv_pkg::phase_t    phase_nxt,
  output logic [2:0]          lit_idx_nxt,
  output logic [2:0]          top_kind_nxt,
  output jssv_pkg::stack_op_t op,
  output logic                res_valid,
  output logic [3:0]          res_status,
  output logic [2:0]          res_kind
);
  import jssv_pkg::*;

  logic          do_disp, do_close, do_vdone;
  logic          in_array;
  logic [DW-1:0] depth_eff;
  logic          emit;
  logic [3:0]    status;
  phase_t        ph;
  logic [2:0]    li;
  logic [2:0]    kind;
  logic [2:0]    li_inc;
  logic          post_arr;
  logic [DW-1:0] post_depth;
  logic [3:0]    end_err;

  always_comb begin
    do_disp    = 1'b0;
    do_close   = 1'b0;
    do_vdone   = 1'b0;
    emit       = 1'b0;
    status     = ST_OK;
    ph         = phase;
    li         = lit_idx;
    kind       = top_kind;
    op         = '0;
    depth_eff  = depth;
    in_array   = (depth != '0) && top_is_array;
    li_inc     = lit_idx + 3'd1;
    post_arr   = top_is_array;
    post_depth = depth;
    end_err    = ST_EXP_VALUE;

    // Phase decode
    case (phase)
      PH_VALUE: begin
        if (!is_ws(byte_value)) do_disp = 1'b1;
      end
      PH_OBJ_OPEN: begin
        if (byte_value == CH_RBRACE) begin
          do_close = 1'b1;
        end else if (byte_value == CH_QUOTE) begin
          ph = PH_KEY_STR;
        end else if (!is_ws(byte_value)) begin
          emit = 1'b1; status = ST_BAD_LIST;
        end
      end
      PH_ARR_OPEN: begin
        if (byte_value == CH_RBRACK) begin
          do_close = 1'b1;
        end else if (is_ws(byte_value)) begin
          ph = PH_VALUE;
        end else begin
          do_disp = 1'b1;
        end
      end
      PH_STR: begin
        if (byte_value == CH_QUOTE) do_vdone = 1'b1;
      end
      PH_KEY_STR: begin
        if (byte_value == CH_QUOTE) ph = PH_AFTER_KEY;
      end
      PH_AFTER_KEY: begin
        if (byte_value == CH_COLON) begin
          ph = PH_VALUE;
        end else if (!is_ws(byte_value)) begin
          emit = 1'b1; status = ST_EXP_COLON;
        end
      end
      PH_LIT_T: begin
        if (lit_idx < LEN_TRUE && byte_value == true_char(lit_idx)) begin
          li = li_inc;
          if (li_inc == LEN_TRUE) begin
            li = '0;
            if (depth == '0) kind = KIND_BOOL;
            do_vdone = 1'b1;
          end
        end else begin
          emit = 1'b1; status = ST_EXP_TRUE;
        end
      end
      PH_LIT_F: begin
        if (lit_idx < LEN_FALSE && byte_value == false_char(lit_idx)) begin
          li = li_inc;
          if (li_inc == LEN_FALSE) begin
            li = '0;
            if (depth == '0) kind = KIND_BOOL;
            do_vdone = 1'b1;
          end
        end else begin
          emit = 1'b1; status = ST_EXP_FALSE;
        end
      end
      PH_AFTER_VAL: begin
        if (!is_ws(byte_value)) begin
          if (byte_value == CH_COMMA) begin
            ph = in_array ? PH_ARR_COMMA : PH_OBJ_COMMA;
          end else if (byte_value == (in_array ? CH_RBRACK : CH_RBRACE)) begin
            do_close = 1'b1;
          end else begin
            emit = 1'b1; status = in_array ? ST_EXP_RBRACK : ST_EXP_RBRACE;
          end
        end
      end
      PH_OBJ_COMMA: begin
        if (byte_value == CH_QUOTE) begin
          ph = PH_KEY_STR;
        end else if (!is_ws(byte_value)) begin
          emit = 1'b1; status = ST_BAD_LIST;
        end
      end
      PH_ARR_COMMA: begin
        if (is_ws(byte_value)) begin
          ph = PH_VALUE;
        end else begin
          do_disp = 1'b1;
        end
      end
      default: ;
    endcase

    // Start of a value
    if (do_disp) begin
      if (byte_value == CH_LBRACE || byte_value == CH_LBRACK) begin
        if (depth >= DW'(MAX_DEPTH)) begin
          emit = 1'b1; status = ST_TOO_DEEP;
        end else begin
          if (depth == '0) kind = (byte_value == CH_LBRACK) ? KIND_ARRAY : KIND_OBJECT;
          op.push     = 1'b1;
          op.is_array = (byte_value == CH_LBRACK);
          ph = (byte_value == CH_LBRACK) ? PH_ARR_OPEN : PH_OBJ_OPEN;
        end
      end else if (byte_value == CH_QUOTE) begin
        if (depth == '0) kind = KIND_STRING;
        ph = PH_STR;
      end else if (byte_value == CH_T) begin
        li = 3'd1;
        ph = PH_LIT_T;
      end else if (byte_value == CH_F) begin
        li = 3'd1;
        ph = PH_LIT_F;
      end else begin
        emit = 1'b1; status = ST_UNSUPPORTED;
      end
    end

    // Closing bracket pops one level
    if (do_close) begin
      if (depth != '0) begin
        op.pop    = 1'b1;
        depth_eff = depth - DW'(1);
      end
      do_vdone = 1'b1;
    end

    // Completed value: top level finishes, otherwise wait for separator
    if (do_vdone) begin
      if (depth_eff == '0) begin
        emit = 1'b1; status = ST_OK;
      end else begin
        ph = PH_AFTER_VAL;
      end
    end

    if (emit) ph = PH_DONE;

    // Stack view after this byte, for the end-of-input error
    if (op.push) begin
      post_depth = depth + DW'(1);
      post_arr   = op.is_array;
    end else if (op.pop) begin
      post_depth = depth - DW'(1);
      post_arr   = below_is_array;
    end

    case (ph)
      PH_OBJ_OPEN:                  end_err = ST_EXP_RBRACE;
      PH_ARR_OPEN:                  end_err = ST_EXP_RBRACK;
      PH_STR, PH_KEY_STR:           end_err = ST_EXP_STR_END;
      PH_AFTER_KEY:                 end_err = ST_EXP_COLON;
      PH_LIT_T:                     end_err = ST_EXP_TRUE;
      PH_LIT_F:                     end_err = ST_EXP_FALSE;
      PH_AFTER_VAL: begin
        end_err = (post_depth != '0 && post_arr) ? ST_EXP_RBRACK : ST_EXP_RBRACE;
      end
      PH_OBJ_COMMA, PH_ARR_COMMA:   end_err = ST_BAD_LIST;
      default:                      end_err = ST_EXP_VALUE;
    endcase

    // Final byte: report if still open, then start a fresh document
    res_valid  = emit;
    res_status = status;
    res_kind   = kind;
    if (last_byte) begin
      if (!emit && phase != PH_DONE) begin
        res_valid  = 1'b1;
        res_status = end_err;
      end
      ph       = PH_VALUE;
      li       = '0;
      kind     = KIND_NONE;
      op.clear = 1'b1;
    end

    phase_nxt    = ph;
    lit_idx_nxt  = li;
    top_kind_nxt = kind;
  end

endmodule

// ----- hw/rtl/json_subset_stream_validator.sv -----
// Top level of the JSON subset stream validator: parser state, stack and result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one document byte per transfer in
//   in_byte_value, with in_last_byte set on the final byte of a document.
//   Output channel (out_valid/out_ready) carries at most one result per
//   document: out_status and out_top_kind. A result appears at the first
//   syntax error, when the top value completes, or on the final byte with the
//   end-of-input error of the current phase. Bytes after a result are consumed
//   silently until the final byte, after which the parser starts a new document.
//   A result is presented in the cycle after the byte that caused it.
//   Throughput: one byte per cycle while in_ready is high; the parser state
//   and the top-of-stack bit are updated together, and the entry below the
//   top is prefetched from the nesting RAM so a pop never waits on the RAM read.
//   Stalls: in_ready drops only while a result is held and out_ready is low;
//   the held result stays stable until taken.
//   Reset (rst_n low, synchronous): parser idle, no nesting, no result pending.
//   The nesting RAM is not cleared; only levels written earlier are read.
module json_subset_stream_validator #(
  parameter int MAX_DEPTH = jssv_pkg::DEFAULT_MAX_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_status,
  output logic [2:0] out_top_kind
);
  import jssv_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);

  phase_t        phase_r, phase_nxt;
  logic [2:0]    lit_idx_r, lit_idx_nxt;
  logic [2:0]    top_kind_r, top_kind_nxt;
  logic [DW-1:0] depth;
  logic          top_is_array, below_is_array;
  stack_op_t     op;
  logic          res_valid;
  logic [3:0]    res_status;
  logic [2:0]    res_kind;
  logic          in_xfer;
  logic          out_valid_r;
  logic [3:0]    out_status_r;
  logic [2:0]    out_kind_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  jssv_step #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_step (
    .phase          (phase_r),
    .lit_idx        (lit_idx_r),
    .top_kind       (top_kind_r),
    .depth          (depth),
    .top_is_array   (top_is_array),
    .below_is_array (below_is_array),
    .byte_value     (in_byte_value),
    .last_byte      (in_last_byte),
    .phase_nxt      (phase_nxt),
    .lit_idx_nxt    (lit_idx_nxt),
    .top_kind_nxt   (top_kind_nxt),
    .op             (op),
    .res_valid      (res_valid),
    .res_status     (res_status),
    .res_kind       (res_kind)
  );

  jssv_stack #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_stack (
    .clk            (clk),
    .rst_n          (rst_n),
    .op_en          (in_xfer),
    .op             (op),
    .depth          (depth),
    .top_is_array   (top_is_array),
    .below_is_array (below_is_array)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_VALUE;
      lit_idx_r  <= '0;
      top_kind_r <= KIND_NONE;
    end else if (in_xfer) begin
      phase_r    <= phase_nxt;
      lit_idx_r  <= lit_idx_nxt;
      top_kind_r <= top_kind_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      out_status_r <= res_status;
      out_kind_r   <= res_kind;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_top_kind = out_kind_r;

endmodule

// ----- test/json_subset_stream_validator_tb.sv -----
// Self-checking testbench for the JSON subset stream validator.
module json_subset_stream_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import jssv_pkg::*;

  localparam int NEST_LIMIT = DEFAULT_MAX_DEPTH;
  localparam int RUN_LIMIT_NS = 1_000_000;
  localparam string WORD_TRUE = "true";
  localparam string WORD_FALSE = "false";

  typedef struct packed {
    logic [3:0] status;
    logic [2:0] kind;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte_value = '0;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_status;
  logic [2:0] out_top_kind;

  json_subset_stream_validator #(
    .MAX_DEPTH(NEST_LIMIT)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte_value(in_byte_value),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_top_kind (out_top_kind)
  );

  // Mirror of the parser state
  phase_t                parse_state;
  logic [2:0]            letter_idx;
  logic [NEST_LIMIT-1:0] level_is_array;
  int                    open_levels;
  logic                  reported;
  logic [2:0]            top_kind_seen;

  verdict_t    pending_verdicts[$];
  logic [7:0]  doc_bytes[$];
  int          mismatches = 0;
  int unsigned bytes_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned hold_cycles = 0;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------------
  function automatic bit is_blank(logic [7:0] c);
    case (c)
      CH_SPACE, CH_LF, CH_CR, CH_TAB: return 1'b1;
      default:                        return 1'b0;
    endcase
  endfunction

  function automatic void clear_parser();
    parse_state    = PH_VALUE;
    letter_idx     = '0;
    level_is_array = '0;
    open_levels    = 0;
    reported       = 1'b0;
    top_kind_seen  = KIND_NONE;
  endfunction

  // One verdict per document; everything after it is ignored
  function automatic void report_status(logic [3:0] st);
    pending_verdicts.push_back('{status: st, kind: top_kind_seen});
    reported    = 1'b1;
    parse_state = PH_DONE;
  endfunction

  function automatic void finish_value();
    if (open_levels == 0) begin
      report_status(ST_OK);
    end else begin
      parse_state = PH_AFTER_VAL;
    end
  endfunction

  function automatic logic in_array_level();
    if (open_levels == 0) return 1'b0;
    return level_is_array[open_levels-1];
  endfunction

  function automatic void open_level(logic is_arr);
    if (open_levels >= NEST_LIMIT) begin
      report_status(ST_TOO_DEEP);
    end else begin
      if (open_levels == 0) top_kind_seen = is_arr ? KIND_ARRAY : KIND_OBJECT;
      level_is_array[open_levels] = is_arr;
      open_levels++;
      if (is_arr) parse_state = PH_ARR_OPEN;
      else parse_state = PH_OBJ_OPEN;
    end
  endfunction

  function automatic void close_level();
    if (open_levels > 0) open_levels--;
    finish_value();
  endfunction

  // First byte of any value
  function automatic void start_value(logic [7:0] c);
    case (c)
      CH_LBRACE: open_level(1'b0);
      CH_LBRACK: open_level(1'b1);
      CH_QUOTE: begin
        if (open_levels == 0) top_kind_seen = KIND_STRING;
        parse_state = PH_STR;
      end
      CH_T: begin
        letter_idx  = 3'd1;
        parse_state = PH_LIT_T;
      end
      CH_F: begin
        letter_idx  = 3'd1;
        parse_state = PH_LIT_F;
      end
      default: report_status(ST_UNSUPPORTED);
    endcase
  endfunction

  // Next letter of true/false; boolean kind is known only once complete
  function automatic void match_letter(logic [7:0] c, bit is_true);
    int         len;
    logic [7:0] want;
    len  = is_true ? 4 : 5;
    want = 8'h00;
    if (letter_idx < len) want = is_true ? WORD_TRUE[letter_idx] : WORD_FALSE[letter_idx];
    if (letter_idx < len && c == want) begin
      letter_idx++;
      if (letter_idx == len) begin
        letter_idx = '0;
        if (open_levels == 0) top_kind_seen = KIND_BOOL;
        finish_value();
      end
    end else begin
      report_status(is_true ? ST_EXP_TRUE : ST_EXP_FALSE);
    end
  endfunction

  function automatic logic [3:0] end_of_input_status();
    case (parse_state)
      PH_OBJ_OPEN:               return ST_EXP_RBRACE;
      PH_ARR_OPEN:               return ST_EXP_RBRACK;
      PH_STR, PH_KEY_STR:        return ST_EXP_STR_END;
      PH_AFTER_KEY:              return ST_EXP_COLON;
      PH_LIT_T:                  return ST_EXP_TRUE;
      PH_LIT_F:                  return ST_EXP_FALSE;
      PH_AFTER_VAL:              return in_array_level() ? ST_EXP_RBRACK : ST_EXP_RBRACE;
      PH_OBJ_COMMA, PH_ARR_COMMA: return ST_BAD_LIST;
      default:                   return ST_EXP_VALUE;
    endcase
  endfunction

  // Advance the mirror by one accepted byte, queueing any verdict it causes
  function automatic void validate_byte(logic [7:0] c, logic last);
    logic in_arr;
    in_arr = in_array_level();
    case (parse_state)
      PH_VALUE: if (!is_blank(c)) start_value(c);
      PH_OBJ_OPEN: begin
        if (c == CH_RBRACE) close_level();
        else if (c == CH_QUOTE) parse_state = PH_KEY_STR;
        else if (!is_blank(c)) report_status(ST_BAD_LIST);
      end
      PH_ARR_OPEN: begin
        if (c == CH_RBRACK) close_level();
        else if (is_blank(c)) parse_state = PH_VALUE;
        else start_value(c);
      end
      PH_STR: if (c == CH_QUOTE) finish_value();
      PH_KEY_STR: if (c == CH_QUOTE) parse_state = PH_AFTER_KEY;
      PH_AFTER_KEY: begin
        if (c == CH_COLON) parse_state = PH_VALUE;
        else if (!is_blank(c)) report_status(ST_EXP_COLON);
      end
      PH_LIT_T: match_letter(c, 1'b1);
      PH_LIT_F: match_letter(c, 1'b0);
      PH_AFTER_VAL: begin
        if (!is_blank(c)) begin
          if (c == CH_COMMA) begin
            if (in_arr) parse_state = PH_ARR_COMMA;
            else parse_state = PH_OBJ_COMMA;
          end else if ((in_arr && c == CH_RBRACK) || (!in_arr && c == CH_RBRACE)) begin
            close_level();
          end else begin
            report_status(in_arr ? ST_EXP_RBRACK : ST_EXP_RBRACE);
          end
        end
      end
      PH_OBJ_COMMA: begin
        if (c == CH_QUOTE) parse_state = PH_KEY_STR;
        else if (!is_blank(c)) report_status(ST_BAD_LIST);
      end
      PH_ARR_COMMA: begin
        if (is_blank(c)) parse_state = PH_VALUE;
        else start_value(c);
      end
      default: ;
    endcase
    if (last) begin
      if (!reported) report_status(end_of_input_status());
      clear_parser();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Document builders
  // ---------------------------------------------------------------------------
  function automatic void add_text(string s);
    foreach (s[i]) doc_bytes.push_back(s[i]);
  endfunction

  function automatic void add_blanks();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(3))
          0:       doc_bytes.push_back(CH_SPACE);
          1:       doc_bytes.push_back(CH_LF);
          2:       doc_bytes.push_back(CH_CR);
          default: doc_bytes.push_back(CH_TAB);
        endcase
      end
    end
  endfunction

  // Strings carry arbitrary bytes apart from the closing quote
  function automatic void gen_string();
    logic [7:0] b;
    doc_bytes.push_back(CH_QUOTE);
    repeat ($urandom_range(4)) begin
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE) b = 8'hA2;
      doc_bytes.push_back(b);
    end
    doc_bytes.push_back(CH_QUOTE);
  endfunction

  function automatic void gen_value(int lvl);
    int pick;
    int n;
    pick = $urandom_range(99);
    if (lvl < 3 && pick < 22) begin
      add_text("{");
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) begin
        if (i != 0) add_text(",");
        add_blanks();
        gen_string();
        add_blanks();
        add_text(":");
        add_blanks();
        gen_value(lvl + 1);
        add_blanks();
      end
      if (n == 0) add_blanks();
      add_text("}");
    end else if (lvl < 3 && pick < 44) begin
      add_text("[");
      n = $urandom_range(3);
      // empty arrays rarely get a blank inside, which the block rejects
      if (n == 0 && $urandom_range(7) == 0) add_text(" ");
      for (int i = 0; i < n; i++) begin
        if (i != 0) add_text(",");
        add_blanks();
        gen_value(lvl + 1);
        add_blanks();
      end
      add_text("]");
    end else if (pick < 66) begin
      gen_string();
    end else if (pick < 80) begin
      add_text("true");
    end else if (pick < 94) begin
      add_text("false");
    end else begin
      case ($urandom_range(2))
        0:       add_text("null");
        1:       add_text("-12");
        default: add_text("7");
      endcase
    end
  endfunction

  // Mostly well-formed documents, some damaged, a few pure noise
  function automatic void make_random_doc();
    int pos;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) doc_bytes.push_back(8'($urandom_range(255)));
    end else begin
      add_blanks();
      gen_value(0);
      case ($urandom_range(9))
        6: doc_bytes[$urandom_range(doc_bytes.size() - 1)] = 8'($urandom_range(255));
        7: begin
          pos = $urandom_range(1, doc_bytes.size());
          while (doc_bytes.size() > pos) void'(doc_bytes.pop_back());
        end
        8: begin
          add_blanks();
          repeat ($urandom_range(1, 3)) doc_bytes.push_back(8'($urandom_range(255)));
        end
        9: doc_bytes.insert($urandom_range(doc_bytes.size() - 1), 8'($urandom_range(255)));
        default: ;
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Called right after a rising edge; returns at the edge of the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_value <= b;
    in_last_byte  <= last;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (took !== 1'b1);
    bytes_sent++;
    validate_byte(b, last);
  endtask

  task automatic send_doc();
    int n;
    n = doc_bytes.size();
    for (int i = 0; i < n; i++) send_byte(doc_bytes[i], i == n - 1);
    doc_bytes.delete();
  endtask

  task automatic send_text(string s);
    add_text(s);
    send_doc();
  endtask

  // Sender goes idle until every expected result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------
  // Receiver readiness; a requested hold-off is counted down here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic note_mismatch(string what, verdict_t want, verdict_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected status %0d kind %0d, got status %0d kind %0d",
               $time, what, want.status, want.kind, got.status, got.kind);
  endtask

  // Result checker: sample between edges, compare on the transfer edge
  initial begin
    verdict_t got;
    verdict_t want;
    logic     take;
    forever begin
      @(negedge clk);
      take       = rst_n && out_valid && out_ready;
      got.status = out_status;
      got.kind   = out_top_kind;
      @(posedge clk);
      if (take === 1'b1) begin
        if (pending_verdicts.size() == 0) begin
          note_mismatch("unexpected result", 'x, got);
        end else begin
          want = pending_verdicts.pop_front();
          if (want.status !== got.status || want.kind !== got.kind)
            note_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every status but the depth error, every top kind and the parser's quirks
  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_text("{}");
    send_text("[]");
    doc_bytes = '{CH_QUOTE, 8'h00, 8'hFF, CH_QUOTE};
    send_doc();
    send_text(" ");              // nothing but blanks
    send_text("n");              // null is unsupported
    send_text("[ ]");            // blank inside an empty array
    send_text("{\"\":[]");       // object left open after a value
    send_text("[");
    send_text("{\"");            // key never closed
    send_text("t");              // broken literal reports no kind
    send_text("fx");
    send_text("{\"\"x");         // missing colon
    send_text("[[],]");          // comma then close bracket
    send_text("[[], ");          // comma, blank, end
    send_text("{\"\":[],}");     // trailing comma in an object
    send_text("true ]x");        // bytes after the top value are ignored
  endtask

  // Receiver holds off while the sender keeps going, then a full pause
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 300;
    repeat (30) begin
      case ($urandom_range(2))
        0:       send_text("[]");
        1:       send_text("true");
        default: send_text("{}");
      endcase
    end
    wait_for_results();
    repeat (5) send_text("[true,false]");
  endtask

  // Nesting around the depth limit with a random mix of container types
  task automatic test_deep_nesting(int levels);
    bit kinds[$];
    for (int i = 0; i < levels; i++) begin
      kinds.push_back(1'($urandom_range(1)));
      if (kinds[i]) add_text("[");
      else add_text("{\"\":");
    end
    add_text("true");
    while (kinds.size() != 0) begin
      if (kinds.pop_back()) add_text("]");
      else add_text("}");
    end
    send_doc();
  endtask

  task automatic test_random_docs(int unsigned target, int s_pct, int r_pct);
    int unsigned stop_at;
    stop_at        = bytes_sent + target;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    while (bytes_sent < stop_at) begin
      make_random_doc();
      send_doc();
    end
  endtask

  initial begin
    clear_parser();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_backpressure();
    test_deep_nesting(NEST_LIMIT);
    test_deep_nesting(NEST_LIMIT + 1);
    test_deep_nesting($urandom_range(NEST_LIMIT - 4, NEST_LIMIT + 2));
    test_random_docs(265, 0, 0);
    test_random_docs(265, 65, 0);
    test_random_docs(265, 0, 65);
    test_random_docs(265, 14, 14);

    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && pending_verdicts.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_verdicts.size() != 0)
      $display("%0d expected results never arrived", pending_verdicts.size());
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("run exceeded its time limit");
    $display("FAILURE");
    $finish;
  end

endmodule
